// File: rtl/core/itt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_pkg
// Types, codes and scan functions shared by the IR text tokenizer.
// ----------------------------------------------------------------------------
package itt_pkg;

    localparam int LINE_BITS   = 24;
    localparam int OFFSET_BITS = 32;
    localparam int VALUE_BITS  = 64;
    localparam int KIND_BITS   = 5;
    localparam int MODE_BITS   = 4;
    localparam int FLAG_BITS   = 4;
    localparam int MAX_TOKENS  = 3;
    localparam int TCNT_BITS   = 2;

    localparam logic [LINE_BITS-1:0]  LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] CAP_MAG  = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Scanner modes.
    localparam logic [MODE_BITS-1:0] M_IDLE    = 4'd0;
    localparam logic [MODE_BITS-1:0] M_COMMENT = 4'd1;
    localparam logic [MODE_BITS-1:0] M_SEMI2   = 4'd2;
    localparam logic [MODE_BITS-1:0] M_ARROW2  = 4'd3;
    localparam logic [MODE_BITS-1:0] M_DIR     = 4'd4;
    localparam logic [MODE_BITS-1:0] M_VAL     = 4'd5;
    localparam logic [MODE_BITS-1:0] M_LAB     = 4'd6;
    localparam logic [MODE_BITS-1:0] M_IDENT   = 4'd7;
    localparam logic [MODE_BITS-1:0] M_ZERO    = 4'd8;
    localparam logic [MODE_BITS-1:0] M_DEC     = 4'd9;
    localparam logic [MODE_BITS-1:0] M_HEX     = 4'd10;

    // Number flag bits.
    localparam int F_NEG   = 0;
    localparam int F_HEX   = 1;
    localparam int F_POINT = 2;
    localparam int F_OVF   = 3;

    // Token kinds.
    localparam logic [KIND_BITS-1:0] K_END    = 5'd0;
    localparam logic [KIND_BITS-1:0] K_SEMI   = 5'd1;
    localparam logic [KIND_BITS-1:0] K_SEMI2  = 5'd2;
    localparam logic [KIND_BITS-1:0] K_ARROW  = 5'd3;
    localparam logic [KIND_BITS-1:0] K_COLON  = 5'd4;
    localparam logic [KIND_BITS-1:0] K_COMMA  = 5'd5;
    localparam logic [KIND_BITS-1:0] K_EQUAL  = 5'd6;
    localparam logic [KIND_BITS-1:0] K_LPAREN = 5'd7;
    localparam logic [KIND_BITS-1:0] K_RPAREN = 5'd8;
    localparam logic [KIND_BITS-1:0] K_LBRACK = 5'd9;
    localparam logic [KIND_BITS-1:0] K_RBRACK = 5'd10;
    localparam logic [KIND_BITS-1:0] K_LBRACE = 5'd11;
    localparam logic [KIND_BITS-1:0] K_RBRACE = 5'd12;
    localparam logic [KIND_BITS-1:0] K_DIR    = 5'd13;
    localparam logic [KIND_BITS-1:0] K_VAL    = 5'd14;
    localparam logic [KIND_BITS-1:0] K_LAB    = 5'd15;
    localparam logic [KIND_BITS-1:0] K_INT    = 5'd16;
    localparam logic [KIND_BITS-1:0] K_FLOAT  = 5'd17;
    localparam logic [KIND_BITS-1:0] K_IDENT  = 5'd18;
    localparam logic [KIND_BITS-1:0] K_UNEXP  = 5'd19;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   column;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] length;
        logic [VALUE_BITS-1:0]  value;
    } token_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [FLAG_BITS-1:0]   flags;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   column;
        logic [OFFSET_BITS-1:0] offset;
        logic [LINE_BITS-1:0]   tok_line;
        logic [LINE_BITS-1:0]   tok_column;
        logic [OFFSET_BITS-1:0] tok_offset;
        logic [VALUE_BITS-1:0]  accum;
    } state_t;

    typedef struct packed {
        state_t                  st;
        logic [TCNT_BITS-1:0]    count;
        token_t [MAX_TOKENS-1:0] toks;
    } scan_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_start(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_body(input logic [7:0] c);
        return is_start(c) || is_digit(c) || (c == ".");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_digit(c)) d = c - 8'h30;
        else if ((c >= "a") && (c <= "f")) d = c - 8'h57;
        else d = c - 8'h37;
        return d[3:0];
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            "=":     k = K_EQUAL;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic scan_t consume(input scan_t s, input logic [7:0] c);
        scan_t r;
        r = s;
        if (c == 8'h0A) begin
            if (r.st.line != LINE_MAX) r.st.line = r.st.line + 1'b1;
            r.st.column = {{(LINE_BITS-1){1'b0}}, 1'b1};
        end else if (r.st.column != LINE_MAX) begin
            r.st.column = r.st.column + 1'b1;
        end
        r.st.offset = r.st.offset + 1'b1;
        return r;
    endfunction

    function automatic scan_t start_token(input scan_t s);
        scan_t r;
        r = s;
        r.st.tok_line   = r.st.line;
        r.st.tok_column = r.st.column;
        r.st.tok_offset = r.st.offset;
        return r;
    endfunction

    function automatic scan_t emit(input scan_t s, input logic [KIND_BITS-1:0] kind,
                                   input logic [OFFSET_BITS-1:0] len,
                                   input logic [VALUE_BITS-1:0] val);
        scan_t r;
        r = s;
        if (r.count != TCNT_BITS'(MAX_TOKENS)) begin
            r.toks[r.count].kind   = kind;
            r.toks[r.count].line   = r.st.tok_line;
            r.toks[r.count].column = r.st.tok_column;
            r.toks[r.count].offset = r.st.tok_offset;
            r.toks[r.count].length = len;
            r.toks[r.count].value  = val;
            r.count = r.count + 1'b1;
        end
        return r;
    endfunction

    // Multiply-accumulate with saturation flag: overflow when acc*base+d > 2^63.
    function automatic scan_t accumulate(input scan_t s, input logic [3:0] d,
                                         input logic hex);
        scan_t r;
        logic [VALUE_BITS+3:0] p;
        r = s;
        if (hex) p = {r.st.accum, 4'd0} + (VALUE_BITS+4)'(d);
        else p = {3'd0, r.st.accum, 1'b0} + {1'b0, r.st.accum, 3'd0}
                 + (VALUE_BITS+4)'(d);
        if (!r.st.flags[F_OVF]) begin
            if (p > (VALUE_BITS+4)'(CAP_MAG)) r.st.flags[F_OVF] = 1'b1;
            else r.st.accum = p[VALUE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] int_result(input state_t st);
        logic [VALUE_BITS-1:0] v;
        if (st.flags[F_NEG]) begin
            if (st.flags[F_OVF] || (st.accum > CAP_MAG)) v = CAP_MAG;
            else v = '0 - st.accum;
        end else begin
            if (st.flags[F_OVF] || (st.accum > CAP_MAG - 1'b1)) v = CAP_MAG - 1'b1;
            else v = st.accum;
        end
        return v;
    endfunction

    function automatic scan_t close_open(input scan_t s);
        scan_t r;
        logic [OFFSET_BITS-1:0] len;
        r = s;
        len = r.st.offset - r.st.tok_offset;
        case (r.st.mode)
            M_DIR:   r = emit(r, K_DIR, len, '0);
            M_VAL:   r = emit(r, K_VAL, len, '0);
            M_LAB:   r = emit(r, K_LAB, len, '0);
            M_IDENT: r = emit(r, K_IDENT, len, '0);
            M_ZERO, M_DEC, M_HEX: begin
                if (r.st.flags[F_POINT]) r = emit(r, K_FLOAT, len, '0);
                else r = emit(r, K_INT, len, int_result(r.st));
            end
            default: ;
        endcase
        r.st.mode  = M_IDLE;
        r.st.accum = '0;
        r.st.flags = '0;
        return r;
    endfunction

    function automatic scan_t idle_byte(input scan_t s, input logic [7:0] c,
                                        input logic [7:0] nx, input logic nxv);
        scan_t r;
        logic [KIND_BITS-1:0] sk;
        r = s;
        sk = single_kind(c);
        if ((c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A)) begin
            r = consume(r, c);
        end else if ((c == "/") && nxv && (nx == "/")) begin
            r.st.mode = M_COMMENT;
            r = consume(r, c);
        end else if (c == ";") begin
            r = start_token(r);
            if (nxv && (nx == ";")) r.st.mode = M_SEMI2;
            else r = emit(r, K_SEMI, OFFSET_BITS'(1), '0);
            r = consume(r, c);
        end else if ((c == "-") && nxv && (nx == ">")) begin
            r = start_token(r);
            r.st.mode = M_ARROW2;
            r = consume(r, c);
        end else if (sk != K_END) begin
            r = start_token(r);
            r = emit(r, sk, OFFSET_BITS'(1), '0);
            r = consume(r, c);
        end else if ((c == "@") || (c == "%") || (c == ".")) begin
            r = start_token(r);
            r = consume(r, c);
            r.st.tok_offset = r.st.offset;
            r.st.mode = (c == "@") ? M_DIR : (c == "%") ? M_VAL : M_LAB;
        end else if (is_digit(c) || ((c == "-") && nxv && is_digit(nx))) begin
            r = start_token(r);
            r.st.accum = '0;
            r.st.flags = '0;
            r.st.flags[F_NEG] = (c == "-");
            if (is_digit(c)) r = accumulate(r, hex_val(c), 1'b0);
            r.st.mode = (c == "0") ? M_ZERO : M_DEC;
            r = consume(r, c);
        end else if (is_start(c)) begin
            r = start_token(r);
            r.st.mode = M_IDENT;
            r = consume(r, c);
        end else begin
            r = start_token(r);
            r = emit(r, K_UNEXP, OFFSET_BITS'(1), '0);
            r = consume(r, c);
        end
        return r;
    endfunction

    // Judges one held byte c with one byte of lookahead nx.
    function automatic scan_t process(input scan_t s, input logic [7:0] c,
                                      input logic [7:0] nx, input logic nxv);
        scan_t r;
        logic done;
        r = s;
        done = 1'b0;
        if (r.st.mode == M_COMMENT) begin
            if (c != 8'h0A) begin
                r = consume(r, c);
                done = 1'b1;
            end else begin
                r.st.mode = M_IDLE;
            end
        end else if (r.st.mode == M_SEMI2) begin
            r = emit(r, K_SEMI2, OFFSET_BITS'(2), '0);
            r = consume(r, c);
            r.st.mode = M_IDLE;
            done = 1'b1;
        end else if (r.st.mode == M_ARROW2) begin
            r = emit(r, K_ARROW, OFFSET_BITS'(2), '0);
            r = consume(r, c);
            r.st.mode = M_IDLE;
            done = 1'b1;
        end else if ((r.st.mode == M_DIR) || (r.st.mode == M_VAL) ||
                     (r.st.mode == M_LAB) || (r.st.mode == M_IDENT)) begin
            if (is_body(c)) begin
                r = consume(r, c);
                done = 1'b1;
            end else begin
                r = close_open(r);
            end
        end else if (r.st.mode == M_ZERO) begin
            if ((c == "x") || (c == "X")) begin
                r.st.flags[F_HEX] = 1'b1;
                r.st.mode = M_HEX;
                r = consume(r, c);
                done = 1'b1;
            end else begin
                r.st.mode = M_DEC;
            end
        end
        if (!done && (r.st.mode == M_DEC)) begin
            if (is_digit(c)) begin
                if (!r.st.flags[F_POINT]) r = accumulate(r, hex_val(c), 1'b0);
                r = consume(r, c);
                done = 1'b1;
            end else if ((c == ".") && !r.st.flags[F_POINT] && nxv && is_digit(nx)) begin
                r.st.flags[F_POINT] = 1'b1;
                r = consume(r, c);
                done = 1'b1;
            end else begin
                r = close_open(r);
            end
        end else if (!done && (r.st.mode == M_HEX)) begin
            if (is_hex(c)) begin
                r = accumulate(r, hex_val(c), 1'b1);
                r = consume(r, c);
                done = 1'b1;
            end else begin
                r = close_open(r);
            end
        end
        if (!done) begin
            r.st.mode = M_IDLE;
            r = idle_byte(r, c, nx, nxv);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/ir_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_text_tokenizer
// Streaming tokenizer for a textual IR, one source byte per item.
// ----------------------------------------------------------------------------
// Usage:
// Source text enters on the s_ channel, one byte per item in s_tdata. An item
// with s_tuser set carries no byte; it marks the end of the source, flushes
// any open token and is answered by an end token. Each byte is held back one
// item so it can be judged with one byte of lookahead, so a token appears
// once the byte after it has arrived.
// Tokens leave on the m_ channel. m_tuser carries the token kind, m_tdata the
// position, length and integer value, and m_tlast marks the last token caused
// by one input item. An input item is scanned in the cycle it is accepted; its
// tokens enter the queue then and leave on m_ in order, one per cycle while m_tready is high.
// Throughput is one input item per cycle while each item causes at most one
// token and m_tready stays high; an item that causes two or three tokens holds
// the output until all of them have left. The limit is the four-entry token
// queue: s_tready is high only while the queue has room for three tokens.
// Reset (aresetn low at a clock edge) empties the queue and returns the
// scanner to line 1, column 1, offset 0. When the receiver stalls the queue
// fills and s_tready drops; nothing is lost.
module ir_text_tokenizer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // source_byte
    input  logic         s_tuser,   // end_marker
    output logic         m_tvalid,
    input  logic         m_tready,
    // start_line, start_column, start_offset, text_length, int_value
    output logic [175:0] m_tdata,
    output logic [4:0]   m_tuser,   // token_kind
    output logic         m_tlast    // is_last
);
    import itt_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR   = 2;

    typedef struct packed {
        token_t tok;
        logic   last;
    } qent_t;

    state_t            st_reg, st_next;
    logic [7:0]        held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    qent_t             queue_reg [QDEPTH];
    logic [QPTR-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR:0]     count_reg, count_next;
    scan_t             sc;
    logic              s_accept, m_accept;

    assign s_tready = (count_reg <= (QPTR+1)'(QDEPTH - MAX_TOKENS));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_accept = m_tvalid && m_tready;

    // Whole scan step for one item: judge the held byte, then flush on end.
    always_comb begin
        sc       = '0;
        sc.st    = st_reg;
        if (held_valid_reg) begin
            sc = process(sc, held_reg, s_tdata, !s_tuser);
        end
        if (s_tuser) begin
            sc = close_open(sc);
            sc = start_token(sc);
            sc = emit(sc, K_END, '0, '0);
            held_next       = 8'd0;
            held_valid_next = 1'b0;
        end else begin
            held_next       = s_tdata;
            held_valid_next = 1'b1;
        end
        st_next = sc.st;
    end

    always_comb begin
        count_next = count_reg;
        if (s_accept) count_next = count_next + (QPTR+1)'(sc.count);
        if (m_accept) count_next = count_next - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{mode: M_IDLE, flags: '0,
                        line: LINE_BITS'(1), column: LINE_BITS'(1), offset: '0,
                        tok_line: LINE_BITS'(1), tok_column: LINE_BITS'(1),
                        tok_offset: '0, accum: '0};
            held_reg          <= 8'd0;
            held_valid_reg    <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end else begin
            if (s_accept) begin
                st_reg         <= st_next;
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                wr_ptr_reg     <= wr_ptr_reg + QPTR'(sc.count);
            end
            if (m_accept) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_TOKENS; i++) begin
                if (TCNT_BITS'(i) < sc.count) begin
                    queue_reg[wr_ptr_reg + QPTR'(i)] <=
                        '{tok: sc.toks[i], last: (TCNT_BITS'(i + 1) == sc.count)};
                end
            end
        end
    end

    assign m_tuser = queue_reg[rd_ptr_reg].tok.kind;
    assign m_tlast = queue_reg[rd_ptr_reg].last;
    assign m_tdata = {queue_reg[rd_ptr_reg].tok.value,
                      queue_reg[rd_ptr_reg].tok.length,
                      queue_reg[rd_ptr_reg].tok.offset,
                      queue_reg[rd_ptr_reg].tok.column,
                      queue_reg[rd_ptr_reg].tok.line};

    // The queue never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR+1)'(QDEPTH))
        else $error("token queue overflow");

    // An end item always produces a token, so the output is busy next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> m_tvalid)
        else $error("end item produced no token");

    // After an end item no byte is held for lookahead.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> !held_valid_reg)
        else $error("held byte survived end item");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR text tokenizer: source bytes stream in with
// random gaps, and every token that leaves is checked against a scanner
// model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import itt_pkg::*;

    // Scanner modes of the bench's own scanner.
    typedef enum int {
        S_IDLE, S_COMMENT, S_SEMI2, S_ARROW2, S_DIR, S_VAL, S_LAB, S_IDENT,
        S_ZERO, S_DEC, S_HEX
    } scan_mode_e;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   column;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] length;
        logic [63:0]            value;
        logic                   last;
    } tok_s;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       at_end;
    } src_s;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;

    ir_text_tokenizer dut (.*);

    always #5 aclk = ~aclk;

    // Scanner state of the bench.
    scan_mode_e              mode;
    logic [7:0]              held;
    logic                    held_ok;
    logic [LINE_BITS-1:0]    ln, col, t_ln, t_col;
    logic [OFFSET_BITS-1:0]  offs, t_offs;
    logic [63:0]             accum;
    logic                    f_neg, f_point, f_ovf;
    int                      step_count;

    tok_s  expected_tokens[$];
    src_s  pending_src[$];
    int    errors = 0;
    bit    quiet = 0;       // no idling in the last part of the run
    bit    hold_src = 0;    // sender waits for every token to drain

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit first_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction
    function automatic bit body_ch(logic [7:0] c);
        return first_ch(c) || dig(c) || c == ".";
    endfunction
    function automatic int hexdig(logic [7:0] c);
        if (dig(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    task automatic push_token(logic [KIND_BITS-1:0] k, logic [OFFSET_BITS-1:0] len,
                              logic [63:0] v);
        tok_s t;
        if (step_count >= MAX_TOKENS) return;
        t = '{k, t_ln, t_col, t_offs, len, v, 1'b0};
        expected_tokens.push_back(t);
        step_count++;
    endtask

    task automatic advance(logic [7:0] c);
        if (c == 8'h0A) begin
            if (ln != LINE_MAX) ln++;
            col = 1;
        end else if (col != LINE_MAX) begin
            col++;
        end
        offs++;
    endtask

    task automatic mark_start();
        t_ln = ln; t_col = col; t_offs = offs;
    endtask

    // Saturating multiply-accumulate: overflow once the magnitude passes 2^63.
    task automatic add_digit(int d, int base);
        logic [67:0] p;
        if (f_ovf) return;
        p = {4'd0, accum} * base + d;
        if (p > {4'd0, CAP_MAG}) f_ovf = 1;
        else accum = p[63:0];
    endtask

    function automatic logic [63:0] int_val();
        if (f_neg) return (f_ovf || accum > CAP_MAG) ? CAP_MAG : 64'd0 - accum;
        return (f_ovf || accum > CAP_MAG - 1) ? CAP_MAG - 1 : accum;
    endfunction

    task automatic finish_token();
        logic [OFFSET_BITS-1:0] len;
        len = offs - t_offs;
        case (mode)
            S_DIR:   push_token(K_DIR, len, 0);
            S_VAL:   push_token(K_VAL, len, 0);
            S_LAB:   push_token(K_LAB, len, 0);
            S_IDENT: push_token(K_IDENT, len, 0);
            S_ZERO, S_DEC, S_HEX:
                if (f_point) push_token(K_FLOAT, len, 0);
                else push_token(K_INT, len, int_val());
            default: ;
        endcase
        mode = S_IDLE; accum = 0; f_neg = 0; f_point = 0; f_ovf = 0;
    endtask

    task automatic scan_idle(logic [7:0] c, logic [7:0] nx, bit nxv);
        logic [KIND_BITS-1:0] single;
        case (c)
            ":": single = K_COLON;
            ",": single = K_COMMA;
            "=": single = K_EQUAL;
            "(": single = K_LPAREN;
            ")": single = K_RPAREN;
            "[": single = K_LBRACK;
            "]": single = K_RBRACK;
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            default: single = K_END;
        endcase
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
            advance(c);
        end else if (c == "/" && nxv && nx == "/") begin
            mode = S_COMMENT; advance(c);
        end else if (c == ";") begin
            mark_start();
            if (nxv && nx == ";") mode = S_SEMI2;
            else push_token(K_SEMI, 1, 0);
            advance(c);
        end else if (c == "-" && nxv && nx == ">") begin
            mark_start(); mode = S_ARROW2; advance(c);
        end else if (single != K_END) begin
            mark_start(); push_token(single, 1, 0); advance(c);
        end else if (c == "@" || c == "%" || c == ".") begin
            mark_start(); advance(c);
            t_offs = offs;
            mode = (c == "@") ? S_DIR : (c == "%") ? S_VAL : S_LAB;
        end else if (dig(c) || (c == "-" && nxv && dig(nx))) begin
            mark_start();
            accum = 0; f_point = 0; f_ovf = 0;
            f_neg = (c == "-");
            if (dig(c)) add_digit(c - "0", 10);
            mode = (c == "0") ? S_ZERO : S_DEC;
            advance(c);
        end else if (first_ch(c)) begin
            mark_start(); mode = S_IDENT; advance(c);
        end else begin
            mark_start(); push_token(K_UNEXP, 1, 0); advance(c);
        end
    endtask

    // Judges a held byte against its lookahead; a zero that is not followed
    // by x or X falls through to the decimal rules, the rest to the idle rules.
    task automatic scan_byte(logic [7:0] c, logic [7:0] nx, bit nxv);
        case (mode)
            S_COMMENT: begin
                if (c != 8'h0A) begin advance(c); return; end
                mode = S_IDLE;
            end
            S_SEMI2: begin
                push_token(K_SEMI2, 2, 0); advance(c); mode = S_IDLE; return;
            end
            S_ARROW2: begin
                push_token(K_ARROW, 2, 0); advance(c); mode = S_IDLE; return;
            end
            S_DIR, S_VAL, S_LAB, S_IDENT: begin
                if (body_ch(c)) begin advance(c); return; end
                finish_token();
            end
            S_ZERO: begin
                if (c == "x" || c == "X") begin
                    mode = S_HEX; advance(c); return;
                end
                mode = S_DEC;
                scan_byte(c, nx, nxv);
                return;
            end
            S_DEC: begin
                if (dig(c)) begin
                    if (!f_point) add_digit(c - "0", 10);
                    advance(c); return;
                end
                if (c == "." && !f_point && nxv && dig(nx)) begin
                    f_point = 1; advance(c); return;
                end
                finish_token();
            end
            S_HEX: begin
                if (hexdig(c) < 16) begin add_digit(hexdig(c), 16); advance(c); return; end
                finish_token();
            end
            default: mode = S_IDLE;
        endcase
        scan_idle(c, nx, nxv);
    endtask

    task automatic predict_tokens(src_s it);
        step_count = 0;
        if (it.at_end) begin
            if (held_ok) scan_byte(held, 0, 0);
            held_ok = 0; held = 0;
            finish_token();
            mark_start();
            push_token(K_END, 0, 0);
        end else begin
            if (held_ok) scan_byte(held, it.text_byte, 1);
            held = it.text_byte; held_ok = 1;
        end
        if (step_count > 0) expected_tokens[$].last = 1'b1;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) pending_src.push_back('{s[i], 1'b0});
    endtask
    task automatic add_end();
        pending_src.push_back('{8'd0, 1'b1});
    endtask

    // Driver: presents pending source items with random idle bursts.
    int src_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_tokens('{s_tdata, s_tuser});
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_src.size() > 0 && !hold_src) begin
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        src_gap <= $urandom_range(1, 7) - 1;
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        {s_tdata, s_tuser} <= pending_src.pop_front();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stalls.
    int snk_gap = 0;
    int idle_cycles = 0;
    always @(posedge aclk) begin
        tok_s exp_t;
        if (aresetn) begin
            idle_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ?
                           0 : idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token kind %0d", m_tuser);
                    errors++;
                end else begin
                    exp_t = expected_tokens.pop_front();
                    if (m_tuser !== exp_t.kind) begin
                        $error("token_kind exp %0d got %0d", exp_t.kind, m_tuser); errors++;
                    end
                    if (m_tdata[23:0] !== exp_t.line) begin
                        $error("start_line exp %0d got %0d", exp_t.line, m_tdata[23:0]);
                        errors++;
                    end
                    if (m_tdata[47:24] !== exp_t.column) begin
                        $error("start_column exp %0d got %0d", exp_t.column, m_tdata[47:24]);
                        errors++;
                    end
                    if (m_tdata[79:48] !== exp_t.offset) begin
                        $error("start_offset exp %0d got %0d", exp_t.offset, m_tdata[79:48]);
                        errors++;
                    end
                    if (m_tdata[111:80] !== exp_t.length) begin
                        $error("text_length exp %0d got %0d", exp_t.length, m_tdata[111:80]);
                        errors++;
                    end
                    if (m_tdata[175:112] !== exp_t.value) begin
                        $error("int_value exp %0d got %0d", $signed(exp_t.value),
                               $signed(m_tdata[175:112]));
                        errors++;
                    end
                    if (m_tlast !== exp_t.last) begin
                        $error("is_last exp %0d got %0d", exp_t.last, m_tlast); errors++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                snk_gap <= $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (idle_cycles > 2000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Random source text: mostly well-formed tokens, some noise bytes.
    task automatic add_random_piece();
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 13))
            0: s = " ";
            1: s = "\n";
            2: s = "// c;x\n";
            3: s = ";";
            4: s = ";;";
            5: s = "->";
            6: s = "(){}[],:=";
            7: begin
                s = ($urandom_range(0, 2) == 0) ? "@" : ($urandom_range(0, 1) ? "%" : ".");
                n = $urandom_range(0, 4);
                repeat (n) s = {s, string'(8'("a" + $urandom_range(0, 25)))};
                if ($urandom_range(0, 1)) s = {s, ".1"};
            end
            8: begin
                s = $urandom_range(0, 1) ? "-" : "";
                n = $urandom_range(1, 21);
                repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            end
            9: begin
                s = $urandom_range(0, 1) ? "0x" : "0X";
                n = $urandom_range(0, 17);
                repeat (n) s = {s, string'(8'($urandom_range(0, 1) ?
                                "a" + $urandom_range(0, 5) : "0" + $urandom_range(0, 9)))};
            end
            10: s = $urandom_range(0, 1) ? "3.14" : "-0.5.2";
            11: begin
                s = "_v";
                n = $urandom_range(0, 3);
                repeat (n) s = {s, string'(8'("A" + $urandom_range(0, 25)))};
            end
            12: pending_src.push_back('{8'($urandom_range(0, 255)), 1'b0});
            default: add_end();
        endcase
        add_text(s);
        add_text(" ");
    endtask

    initial begin
        mode = S_IDLE; held = 0; held_ok = 0;
        ln = 1; col = 1; offs = 0; t_ln = 1; t_col = 1; t_offs = 0;
        accum = 0; f_neg = 0; f_point = 0; f_ovf = 0;

        // Directed part: every punctuation, sigils alone, the number corner
        // cases (saturation both ways, hex above the signed range, bare 0x,
        // floats), lone minus and slash, a NUL byte and a repeated end.
        add_text("; ;;->:,=()[]{}@d.x %v.1 .l @ 9223372036854775808 ");
        add_text("-9223372036854775809 0xFFFFFFFFFFFFFFFF 0x 1.5 7.a - / ");
        pending_src.push_back('{8'h00, 1'b0});
        pending_src.push_back('{8'hFF, 1'b0});
        add_text("//z\nab_9");
        add_end();
        add_end();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_src.size() == 0);
        // Let every token drain before the sender resumes.
        hold_src = 1;
        wait (expected_tokens.size() == 0 && !s_tvalid);
        repeat (10) @(posedge aclk);
        hold_src = 0;

        while (pending_src.size() < 60) add_random_piece();
        add_end();
        wait (pending_src.size() == 0);
        quiet = 1;
        repeat (12) add_random_piece();
        add_end();
        wait (pending_src.size() == 0 && !s_tvalid);
        wait (expected_tokens.size() == 0);
        repeat (20) @(posedge aclk);

        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
